FILE: hdl/md5_message_digest_unit_assert.svh
`ifndef MD5_MESSAGE_DIGEST_UNIT_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define MD5_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define MD5_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/md5_pkg.sv
package md5_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } in_word_t;

  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_low;
  } out_word_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_MARK = 8'h80;

  // Additive constant of each compression step.
  function automatic logic [31:0] round_const(input logic [5:0] s);
    logic [31:0] k;
    case (s)
      6'd0:  k = 32'hD76AA478; 6'd1:  k = 32'hE8C7B756;
      6'd2:  k = 32'h242070DB; 6'd3:  k = 32'hC1BDCEEE;
      6'd4:  k = 32'hF57C0FAF; 6'd5:  k = 32'h4787C62A;
      6'd6:  k = 32'hA8304613; 6'd7:  k = 32'hFD469501;
      6'd8:  k = 32'h698098D8; 6'd9:  k = 32'h8B44F7AF;
      6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
      6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193;
      6'd14: k = 32'hA679438E; 6'd15: k = 32'h49B40821;
      6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
      6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA;
      6'd20: k = 32'hD62F105D; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
      6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6;
      6'd26: k = 32'hF4D50D87; 6'd27: k = 32'h455A14ED;
      6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
      6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A;
      6'd32: k = 32'hFFFA3942; 6'd33: k = 32'h8771F681;
      6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
      6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9;
      6'd38: k = 32'hF6BB4B60; 6'd39: k = 32'hBEBFBC70;
      6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
      6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05;
      6'd44: k = 32'hD9D4D039; 6'd45: k = 32'hE6DB99E5;
      6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
      6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97;
      6'd50: k = 32'hAB9423A7; 6'd51: k = 32'hFC93A039;
      6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
      6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1;
      6'd56: k = 32'h6FA87E4F; 6'd57: k = 32'hFE2CE6E0;
      6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
      6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235;
      6'd62: k = 32'h2AD7D2BB; default: k = 32'hEB86D391;
    endcase
    return k;
  endfunction

  // Left rotation of each step, by round and step within a group of four.
  function automatic logic [4:0] rot_amount(input logic [1:0] rnd, input logic [1:0] j);
    logic [4:0] r;
    unique case ({rnd, j})
      4'h0: r = 5'd7;  4'h1: r = 5'd12; 4'h2: r = 5'd17; 4'h3: r = 5'd22;
      4'h4: r = 5'd5;  4'h5: r = 5'd9;  4'h6: r = 5'd14; 4'h7: r = 5'd20;
      4'h8: r = 5'd4;  4'h9: r = 5'd11; 4'hA: r = 5'd16; 4'hB: r = 5'd23;
      4'hC: r = 5'd6;  4'hD: r = 5'd10; 4'hE: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  // Block word used by each step.
  function automatic logic [3:0] msg_index(input logic [5:0] s);
    logic [3:0] k;
    logic [3:0] w;
    k = s[3:0];
    unique case (s[5:4])
      2'd0:    w = k;
      2'd1:    w = 4'd1 + k * 4'd5;
      2'd2:    w = 4'd5 + k * 4'd3;
      default: w = k * 4'd7;
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/md5_message_digest_unit.sv
// MD5 digest engine. Feed a message as little-endian 32-bit words (first byte
// in bits 7..0); every word but the last carries four bytes, the word marked
// last carries valid_bytes of them (values above four count as four). A word
// that fills no block is taken without a stall. The word that completes a
// 16-word block starts a compression on the one shared round unit: a load
// state, a round state doing one MD5 step per cycle and a fold state, during
// which in_stall stays high. After the last word the engine writes the 0x80
// marker, zero padding and the 64-bit bit length, one padding word per cycle,
// and runs one or two more compressions; the 128-bit digest then appears on
// out_word and the engine returns to the initial chaining values for the next
// message. The digest sits in an output register, so the next message may
// stream in while it waits; the engine only holds in the final fold if the
// previous digest has still not been taken.
`include "md5_message_digest_unit_assert.svh"

module md5_message_digest_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  md5_pkg::in_word_t     in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output md5_pkg::out_word_t    out_word
);

  typedef enum logic [2:0] {
    S_IDLE,   // take message words
    S_PAD,    // write marker, zeros and length into the block
    S_PREP,   // load working state, fetch the first block word
    S_ROUND,  // one MD5 step per cycle
    S_FOLD    // add working state into the chaining state
  } state_t;

  state_t      state_r, state_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [60:0] msg_bytes_r, msg_bytes_nxt;
  logic        pad_r, pad_nxt;           // message ended, padding under way
  logic        need80_r, need80_nxt;     // marker still to be written
  logic        final_blk_r, final_blk_nxt; // current block takes the length
  logic        lastcmp_r, lastcmp_nxt;   // current block is the last one
  logic [31:0] ch_a_r, ch_b_r, ch_c_r, ch_d_r;
  logic [31:0] ch_a_nxt, ch_b_nxt, ch_c_nxt, ch_d_nxt;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt;
  md5_pkg::out_word_t out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Block store: one write port, one registered read port.
  logic [31:0] mem [16];
  logic [31:0] mem_q_r;
  logic        mem_we;
  logic [3:0]  mem_wa;
  logic [31:0] mem_wd;
  logic [3:0]  mem_ra;

  logic        in_accept;
  logic        out_free;
  logic [2:0]  vb_sat;
  logic [31:0] marker_word;
  logic [63:0] bit_len;
  logic [31:0] f_val;
  logic [31:0] t_sum;
  logic [63:0] t_dbl;
  logic [31:0] t_rot;
  logic [4:0]  rot;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign bit_len   = {msg_bytes_r, 3'b000};

  // Saturate the byte count and build the final data word with its marker.
  always_comb begin
    vb_sat = (in_word.valid_bytes > 3'd4) ? 3'd4 : in_word.valid_bytes;
    case (vb_sat[1:0])
      2'd0:    marker_word = {24'h0, md5_pkg::PAD_MARK};
      2'd1:    marker_word = {16'h0, md5_pkg::PAD_MARK, in_word.data_word[7:0]};
      2'd2:    marker_word = {8'h0, md5_pkg::PAD_MARK, in_word.data_word[15:0]};
      default: marker_word = {md5_pkg::PAD_MARK, in_word.data_word[23:0]};
    endcase
  end

  // Shared round unit: add chain, rotate, add b.
  always_comb begin
    unique case (step_r[5:4])
      2'd0:    f_val = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f_val = (b_r & d_r) | (c_r & ~d_r);
      2'd2:    f_val = b_r ^ c_r ^ d_r;
      default: f_val = c_r ^ (b_r | ~d_r);
    endcase
    rot   = md5_pkg::rot_amount(step_r[5:4], step_r[1:0]);
    t_sum = a_r + f_val + mem_q_r + md5_pkg::round_const(step_r);
    t_dbl = {t_sum, t_sum} << rot;
    t_rot = t_dbl[63:32] + b_r;
  end

  // Fetch the word of the next step; in S_PREP that is the word of step zero.
  assign mem_ra = (state_r == S_ROUND) ? md5_pkg::msg_index(step_r + 6'd1)
                                       : md5_pkg::msg_index(6'd0);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    msg_bytes_nxt = msg_bytes_r;
    pad_nxt       = pad_r;
    need80_nxt    = need80_r;
    final_blk_nxt = final_blk_r;
    lastcmp_nxt   = lastcmp_r;
    ch_a_nxt      = ch_a_r;
    ch_b_nxt      = ch_b_r;
    ch_c_nxt      = ch_c_r;
    ch_d_nxt      = ch_d_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_wa        = idx_r;
    mem_wd        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          mem_we  = 1'b1;
          idx_nxt = idx_r + 4'd1;
          if (!in_word.last_word) begin
            mem_wd        = in_word.data_word;
            msg_bytes_nxt = msg_bytes_r + 61'd4;
          end else if (vb_sat != 3'd4) begin
            mem_wd        = marker_word;
            msg_bytes_nxt = msg_bytes_r + 61'(vb_sat);
            pad_nxt       = 1'b1;
            final_blk_nxt = (idx_r <= 4'd13);
          end else begin
            mem_wd        = in_word.data_word;
            msg_bytes_nxt = msg_bytes_r + 61'd4;
            pad_nxt       = 1'b1;
            need80_nxt    = 1'b1;
          end
          if (idx_r == 4'd15) begin
            state_nxt = S_PREP;
          end else if (in_word.last_word) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        mem_we  = 1'b1;
        idx_nxt = idx_r + 4'd1;
        if (need80_r) begin
          mem_wd        = {24'h0, md5_pkg::PAD_MARK};
          need80_nxt    = 1'b0;
          final_blk_nxt = (idx_r <= 4'd13);
        end else if (final_blk_r && idx_r == 4'd14) begin
          mem_wd = bit_len[31:0];
        end else if (final_blk_r && idx_r == 4'd15) begin
          mem_wd      = bit_len[63:32];
          lastcmp_nxt = 1'b1;
        end
        if (idx_r == 4'd15) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        a_nxt     = ch_a_r;
        b_nxt     = ch_b_r;
        c_nxt     = ch_c_r;
        d_nxt     = ch_d_r;
        step_nxt  = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        a_nxt    = d_r;
        d_nxt    = c_r;
        c_nxt    = b_r;
        b_nxt    = t_rot;
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd63) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        if (lastcmp_r) begin
          // Hold here until the previous digest has left.
          if (out_free) begin
            out_nxt.digest_low  = {ch_b_r + b_r, ch_a_r + a_r};
            out_nxt.digest_high = {ch_d_r + d_r, ch_c_r + c_r};
            out_valid_nxt       = 1'b1;
            ch_a_nxt            = md5_pkg::IV_A;
            ch_b_nxt            = md5_pkg::IV_B;
            ch_c_nxt            = md5_pkg::IV_C;
            ch_d_nxt            = md5_pkg::IV_D;
            msg_bytes_nxt       = '0;
            pad_nxt             = 1'b0;
            need80_nxt          = 1'b0;
            final_blk_nxt       = 1'b0;
            lastcmp_nxt         = 1'b0;
            state_nxt           = S_IDLE;
          end
        end else begin
          ch_a_nxt = ch_a_r + a_r;
          ch_b_nxt = ch_b_r + b_r;
          ch_c_nxt = ch_c_r + c_r;
          ch_d_nxt = ch_d_r + d_r;
          if (pad_r) begin
            // Length, and the marker if still due, go in the next block.
            final_blk_nxt = 1'b1;
            state_nxt     = S_PAD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      idx_r       <= '0;
      msg_bytes_r <= '0;
      pad_r       <= 1'b0;
      need80_r    <= 1'b0;
      final_blk_r <= 1'b0;
      lastcmp_r   <= 1'b0;
      ch_a_r      <= md5_pkg::IV_A;
      ch_b_r      <= md5_pkg::IV_B;
      ch_c_r      <= md5_pkg::IV_C;
      ch_d_r      <= md5_pkg::IV_D;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      idx_r       <= idx_nxt;
      msg_bytes_r <= msg_bytes_nxt;
      pad_r       <= pad_nxt;
      need80_r    <= need80_nxt;
      final_blk_r <= final_blk_nxt;
      lastcmp_r   <= lastcmp_nxt;
      ch_a_r      <= ch_a_nxt;
      ch_b_r      <= ch_b_nxt;
      ch_c_r      <= ch_c_nxt;
      ch_d_r      <= ch_d_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    out_r <= out_nxt;
  end

  `MD5_CHECK_NEXT(a_full_block_compresses, mem_we && mem_wa == 4'd15, state_r == S_PREP, "full block did not start a compression")
  `MD5_CHECK_NEXT(a_prep_starts_round, state_r == S_PREP, state_r == S_ROUND && step_r == 6'd0, "round did not start at step zero")
  `MD5_CHECK_NEXT(a_round_ends_fold, state_r == S_ROUND && step_r == 6'd63, state_r == S_FOLD, "round did not end in fold")
  `MD5_CHECK_NOW(a_last_block_flags, lastcmp_r, final_blk_r && pad_r && !need80_r, "last block without length or marker")
  `MD5_CHECK_NOW(a_digest_clears_message, $rose(out_valid_r), idx_r == 4'd0 && msg_bytes_r == 61'd0 && !pad_r, "message state not cleared with digest")

endmodule

FILE: verif/md5_digest_checker.sv
`timescale 1ns / 1ps

module md5_digest_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  md5_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  md5_pkg::out_word_t out_word,
  output int                 errors,
  output int                 pending,
  output int                 digests,
  output int                 spills
);

  localparam logic [31:0] INIT_A   = 32'h67452301;
  localparam logic [31:0] INIT_B   = 32'hefcdab89;
  localparam logic [31:0] INIT_C   = 32'h98badcfe;
  localparam logic [31:0] INIT_D   = 32'h10325476;
  localparam logic [31:0] PAD_BYTE = 32'h80;

  logic [31:0] step_add [64];
  int          shift_amt [16];

  logic [31:0] chain_q [4];
  logic [31:0] blk_w [16];
  logic [3:0]  fill_idx;
  logic [60:0] byte_len;
  int          compress_cnt;

  md5_pkg::out_word_t digest_q [$];

  initial begin
    step_add = '{
      32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
      32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
      32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
      32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
      32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
      32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
      32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
      32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
      32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
      32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
      32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
      32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
      32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
      32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
      32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
      32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
    };
    shift_amt = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
  end

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void clear_hash();
    chain_q[0] = INIT_A;
    chain_q[1] = INIT_B;
    chain_q[2] = INIT_C;
    chain_q[3] = INIT_D;
    fill_idx   = '0;
    byte_len   = '0;
  endfunction

  // 64 steps over the current block, then fold into the chaining state.
  function automatic void compress_block();
    logic [31:0] a, b, c, d, f, t;
    int rnd, k, wi;
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    for (int s = 0; s < 64; s++) begin
      rnd = s / 16;
      k   = s % 16;
      case (rnd)
        0: begin
          f  = (b & c) | (~b & d);
          wi = k;
        end
        1: begin
          f  = (b & d) | (c & ~d);
          wi = (1 + 5 * k) % 16;
        end
        2: begin
          f  = b ^ c ^ d;
          wi = (5 + 3 * k) % 16;
        end
        default: begin
          f  = c ^ (b | ~d);
          wi = (7 * k) % 16;
        end
      endcase
      t = a + f + blk_w[wi] + step_add[s];
      t = rotl(t, shift_amt[rnd * 4 + k % 4]) + b;
      a = d;
      d = c;
      c = b;
      b = t;
    end
    chain_q[0] += a;
    chain_q[1] += b;
    chain_q[2] += c;
    chain_q[3] += d;
    compress_cnt++;
  endfunction

  function automatic void push_block_word(input logic [31:0] w);
    blk_w[fill_idx] = w;
    fill_idx = fill_idx + 4'd1;
    if (fill_idx == 4'd0)
      compress_block();
  endfunction

  // Take one word; on the last word pad, finish and queue the digest.
  function automatic void absorb_word(input md5_pkg::in_word_t w);
    int                 nb;
    int                 start_cnt;
    logic [31:0]        keep;
    logic [63:0]        bit_len;
    md5_pkg::out_word_t dg;
    if (!w.last_word) begin
      push_block_word(w.data_word);
      byte_len = byte_len + 61'd4;
      return;
    end
    start_cnt = compress_cnt;
    nb = (w.valid_bytes > 3'd4) ? 4 : int'(w.valid_bytes);
    byte_len = byte_len + 61'(nb);
    if (nb < 4) begin
      keep = (32'h1 << (8 * nb)) - 32'h1;
      push_block_word((w.data_word & keep) | (PAD_BYTE << (8 * nb)));
    end else begin
      push_block_word(w.data_word);
      push_block_word(PAD_BYTE);
    end
    while (fill_idx != 4'd14)
      push_block_word(32'h0);
    bit_len = {byte_len, 3'b000};
    push_block_word(bit_len[31:0]);
    push_block_word(bit_len[63:32]);
    if (compress_cnt - start_cnt > 1)
      spills++;
    dg.digest_low  = {chain_q[1], chain_q[0]};
    dg.digest_high = {chain_q[3], chain_q[2]};
    digest_q.push_back(dg);
    clear_hash();
  endfunction

  always @(posedge clk) begin
    md5_pkg::out_word_t exp_dg;
    if (!rst_n) begin
      clear_hash();
      digest_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          $display("%0t checker: digest %h arrived with none expected", $time, out_word);
          errors++;
        end else begin
          exp_dg = digest_q.pop_front();
          digests++;
          if (out_word.digest_low !== exp_dg.digest_low) begin
            $display("%0t checker: digest_low expected %h got %h",
                     $time, exp_dg.digest_low, out_word.digest_low);
            errors++;
          end
          if (out_word.digest_high !== exp_dg.digest_high) begin
            $display("%0t checker: digest_high expected %h got %h",
                     $time, exp_dg.digest_high, out_word.digest_high);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall)
        absorb_word(in_word);
    end
    pending = digest_q.size();
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // Rough number of message words to push through.
  localparam int WORD_TARGET = 1650;
  // Drop all idling for this many final words.
  localparam int QUIET_TAIL  = 200;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  md5_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_stall;
  md5_pkg::out_word_t out_word;

  int errors, pending, digests, spills;
  int words_sent = 0;
  int longest    = 0;
  bit idle_on    = 1'b1;

  always #5 clk = ~clk;

  md5_message_digest_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // Watch both channels, predict every digest and compare.
  md5_digest_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .errors    (errors),
    .pending   (pending),
    .digests   (digests),
    .spills    (spills)
  );

  // Present one word at a falling edge and hold it until the engine takes it.
  // Optionally drop valid for a short burst first. Returns at a falling edge.
  task automatic send_word(input md5_pkg::in_word_t w, input bit gaps);
    if (gaps && idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // n_full words of four bytes, then the last word with last_vb bytes.
  // Non-last words carry a random byte count, which the engine must ignore.
  task automatic send_message(input int n_full, input logic [2:0] last_vb, input bit gaps);
    md5_pkg::in_word_t w;
    for (int i = 0; i <= n_full; i++) begin
      w.data_word   = $urandom;
      w.last_word   = (i == n_full);
      w.valid_bytes = (i == n_full) ? last_vb : 3'($urandom_range(0, 7));
      send_word(w, gaps);
    end
    if (n_full + 1 > longest)
      longest = n_full + 1;
  endtask

  // Result side: raise out_stall in random bursts while idling is on.
  initial begin
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    md5_pkg::in_word_t w;
    int                n_full;
    int                sel;
    logic [2:0]        vb;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // One-word messages with every byte count, including the counts above
    // four that act as four; even counts set all bytes, so those past the count must drop.
    for (int v = 0; v < 8; v++) begin
      w.data_word   = (v % 2 == 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
      w.valid_bytes = 3'(v);
      w.last_word   = 1'b1;
      send_word(w, 1'b1);
    end
    // Fourteen full words then a short last word: the marker lands in word
    // fourteen, so the length spills into a second block.
    for (int i = 0; i < 15; i++) begin
      w.data_word   = (i % 2 == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      w.valid_bytes = (i == 14) ? 3'd2 : 3'(i % 8);
      w.last_word   = (i == 14);
      send_word(w, 1'b1);
    end
    if (longest < 15)
      longest = 15;

    // Random messages. Weight lengths around the end of the first and second
    // block, where padding fits or spills into an extra compression.
    while (words_sent < WORD_TARGET) begin
      idle_on = (words_sent < WORD_TARGET - QUIET_TAIL);
      sel = $urandom_range(0, 9);
      if (sel < 5)
        n_full = $urandom_range(0, 17);
      else if (sel < 8)
        n_full = $urandom_range(12, 16);
      else if (sel < 9)
        n_full = $urandom_range(17, 40);
      else
        n_full = $urandom_range(28, 33);
      vb = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      send_message(n_full, vb, $urandom_range(0, 3) != 0);
    end
    in_valid <= 1'b0;

    // Drain: wait for the last digest, then let the engine settle.
    while (pending != 0)
      @(negedge clk);
    repeat (200) @(negedge clk);

    $display("tb_top: %0d words hashed into %0d digests, longest message %0d words",
             words_sent, digests, longest);
    $display("tb_top: %0d messages needed an extra block for padding", spills);
    if (errors == 0 && pending == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb_top: timeout with %0d digests outstanding", pending);
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/md5_pkg.sv
hdl/md5_message_digest_unit.sv
verif/md5_digest_checker.sv
verif/tb_top.sv
